>>> hw/rtl/todc_pkg.sv
// Shared types and constants for the time-of-day clock with LED chaser.
`default_nettype none

package todc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned LED_STEP_TICKS   = 50;

  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned MINUTES_PER_HOUR   = 60;
  localparam int unsigned HOURS_PER_DAY      = 24;
  localparam int unsigned MAX_HOUR           = 23;
  localparam int unsigned MAX_MINUTE         = 59;

  localparam int unsigned TICK_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned LED_CNT_W = $clog2(LED_STEP_TICKS + 1);
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MIN_W     = 6;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned LED_W     = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NUM_CHARS = 4;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PAIR_W    = 7;   // two decimal digits, up to 99

  localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

  localparam logic [LED_W-1:0] LED_FIRST = 4'b0001;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_SWAP = 2'd2
  } todc_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_VALUE  = 2'd2
  } todc_status_e;

  typedef struct packed {
    logic [1:0]                          op;
    logic [NUM_CHARS-1:0][CHAR_W-1:0]    chars;  // [0] hour tens .. [3] minute units
    logic                                new_flag;
  } todc_item_t;

  typedef struct packed {
    todc_status_e        status;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
  } todc_parse_t;

  typedef struct packed {
    todc_status_e        status;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic [LED_W-1:0]    led;
    logic                prev_flag;
  } todc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/time_of_day_clock_with_led_chaser.sv
// Top level: input beat register, clock update logic and result register.
// Path: an accepted input beat waits in the input register and moves on to the
// result register once that is empty or being taken.
// Throughput: one beat per cycle while results are taken; the only loop is
// the state update. The input stays ready while a result waits, as long as
// the input register can move on or is empty. Reset is asynchronous, active
// low: time 00:00:00, first LED lit, changed flag set, both stages empty.
`default_nettype none

module time_of_day_clock_with_led_chaser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // hour_tens_char[7:0], hour_units_char[15:8], minute_tens_char[23:16],
  // minute_units_char[31:24], new_changed_flag[32], zero fill[39:33]
  input  wire  [39:0] s_axis_tdata,
  // op[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[1:0], hours_now[6:2], minutes_now[12:7], seconds_now[18:13],
  // led_pattern[22:19], previous_changed_flag[23]
  output logic [23:0] m_axis_tdata
);

  logic                   in_valid_q, in_valid_d;
  todc_pkg::todc_item_t   in_item_q, in_item;
  logic                   out_valid_q, out_valid_d;
  todc_pkg::todc_result_t out_res_q, res;
  todc_pkg::todc_parse_t  parse;
  logic                   s_accept;
  logic                   adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item.op       = s_axis_tuser;
    in_item.chars[0] = s_axis_tdata[7:0];
    in_item.chars[1] = s_axis_tdata[15:8];
    in_item.chars[2] = s_axis_tdata[23:16];
    in_item.chars[3] = s_axis_tdata[31:24];
    in_item.new_flag = s_axis_tdata[32];
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item;
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  todc_digit_check u_digit_check (
    .item_i  (in_item_q),
    .parse_o (parse)
  );

  todc_time_unit u_time_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .item_i  (in_item_q),
    .parse_i (parse),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.prev_flag, out_res_q.led, out_res_q.seconds,
                          out_res_q.minutes, out_res_q.hours, out_res_q.status};

endmodule

`default_nettype wire

>>> hw/rtl/todc_digit_check.sv
// Parses four ASCII digits HHMM and classifies them for the set-time operation.
`default_nettype none

module todc_digit_check (
  input  wire todc_pkg::todc_item_t  item_i,
  output todc_pkg::todc_parse_t      parse_o
);

  logic [todc_pkg::NUM_CHARS-1:0]    is_nul;
  logic [todc_pkg::NUM_CHARS-1:0]    is_dig;
  logic [todc_pkg::DIGIT_W-1:0]      dig [todc_pkg::NUM_CHARS];
  logic [todc_pkg::PAIR_W-1:0]       hh;
  logic [todc_pkg::PAIR_W-1:0]       mm;

  always_comb begin
    for (int k = 0; k < todc_pkg::NUM_CHARS; k++) begin
      is_nul[k] = (item_i.chars[k] == todc_pkg::ASCII_NUL);
      is_dig[k] = (item_i.chars[k] >= todc_pkg::ASCII_ZERO) &&
                  (item_i.chars[k] <= todc_pkg::ASCII_NINE);
      dig[k]    = todc_pkg::DIGIT_W'(item_i.chars[k] - todc_pkg::ASCII_ZERO);
    end
  end

  assign hh = todc_pkg::PAIR_W'(dig[0]) * todc_pkg::PAIR_W'(10) + todc_pkg::PAIR_W'(dig[1]);
  assign mm = todc_pkg::PAIR_W'(dig[2]) * todc_pkg::PAIR_W'(10) + todc_pkg::PAIR_W'(dig[3]);

  always_comb begin
    parse_o.hours   = todc_pkg::HOUR_W'(hh);
    parse_o.minutes = todc_pkg::MIN_W'(mm);
    if (|is_nul) begin
      parse_o.status = todc_pkg::ST_SYNTAX;
    end else if (!(&is_dig)) begin
      parse_o.status = todc_pkg::ST_VALUE;
    end else if ((hh > todc_pkg::PAIR_W'(todc_pkg::MAX_HOUR)) ||
                 (mm > todc_pkg::PAIR_W'(todc_pkg::MAX_MINUTE))) begin
      parse_o.status = todc_pkg::ST_VALUE;
    end else begin
      parse_o.status = todc_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/todc_time_unit.sv
// Time, LED chaser and changed-flag state with its combinational update logic.
`default_nettype none

module todc_time_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire todc_pkg::todc_item_t  item_i,
  input  wire todc_pkg::todc_parse_t parse_i,
  output todc_pkg::todc_result_t     res_o
);

  logic [todc_pkg::TICK_W-1:0]    tick_q, tick_d, tick_nxt;
  logic [todc_pkg::LED_CNT_W-1:0] led_cnt_q, led_cnt_d, led_cnt_nxt;
  logic [todc_pkg::SEC_W-1:0]     sec_q, sec_d;
  logic [todc_pkg::MIN_W-1:0]     min_q, min_d;
  logic [todc_pkg::HOUR_W-1:0]    hour_q, hour_d;
  logic [todc_pkg::LED_W-1:0]     chaser_q, chaser_d;
  logic                           flag_q, flag_d;
  todc_pkg::todc_status_e         status;

  assign tick_nxt    = tick_q + todc_pkg::TICK_W'(1);
  assign led_cnt_nxt = led_cnt_q + todc_pkg::LED_CNT_W'(1);

  always_comb begin
    tick_d    = tick_q;
    led_cnt_d = led_cnt_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    chaser_d  = chaser_q;
    flag_d    = flag_q;
    status    = todc_pkg::ST_OK;
    case (todc_pkg::todc_op_e'(item_i.op))
      todc_pkg::OP_TICK: begin
        tick_d    = tick_nxt;
        led_cnt_d = led_cnt_nxt;
        // led_cnt tracks tick count modulo the LED step
        if (led_cnt_nxt == todc_pkg::LED_CNT_W'(todc_pkg::LED_STEP_TICKS)) begin
          led_cnt_d = '0;
          chaser_d  = {chaser_q[todc_pkg::LED_W-2:0], chaser_q[todc_pkg::LED_W-1]};
        end
        if (tick_nxt == todc_pkg::TICK_W'(todc_pkg::TICKS_PER_SECOND)) begin
          tick_d    = '0;
          led_cnt_d = '0;
          flag_d    = 1'b1;
          if (sec_q == todc_pkg::SEC_W'(todc_pkg::SECONDS_PER_MINUTE - 1)) begin
            sec_d = '0;
            if (min_q == todc_pkg::MIN_W'(todc_pkg::MINUTES_PER_HOUR - 1)) begin
              min_d = '0;
              if (hour_q == todc_pkg::HOUR_W'(todc_pkg::HOURS_PER_DAY - 1)) begin
                hour_d = '0;
              end else begin
                hour_d = hour_q + todc_pkg::HOUR_W'(1);
              end
            end else begin
              min_d = min_q + todc_pkg::MIN_W'(1);
            end
          end else begin
            sec_d = sec_q + todc_pkg::SEC_W'(1);
          end
        end
      end
      todc_pkg::OP_SET: begin
        status = parse_i.status;
        if (parse_i.status == todc_pkg::ST_OK) begin
          hour_d    = parse_i.hours;
          min_d     = parse_i.minutes;
          sec_d     = '0;
          tick_d    = '0;
          led_cnt_d = '0;
        end
      end
      todc_pkg::OP_SWAP: begin
        flag_d = item_i.new_flag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      led_cnt_q <= '0;
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      chaser_q  <= todc_pkg::LED_FIRST;
      flag_q    <= 1'b1;
    end else if (en_i) begin
      tick_q    <= tick_d;
      led_cnt_q <= led_cnt_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      chaser_q  <= chaser_d;
      flag_q    <= flag_d;
    end
  end

  always_comb begin
    res_o.status    = status;
    res_o.hours     = hour_d;
    res_o.minutes   = min_d;
    res_o.seconds   = sec_d;
    res_o.led       = chaser_d;
    res_o.prev_flag = flag_q;
  end

  a_chaser_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(chaser_q)) else $error("LED chaser not one-hot");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q < todc_pkg::SEC_W'(todc_pkg::SECONDS_PER_MINUTE)) &&
    (min_q < todc_pkg::MIN_W'(todc_pkg::MINUTES_PER_HOUR)) &&
    (hour_q < todc_pkg::HOUR_W'(todc_pkg::HOURS_PER_DAY)))
    else $error("time count out of range");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q < todc_pkg::TICK_W'(todc_pkg::TICKS_PER_SECOND)) &&
    (led_cnt_q < todc_pkg::LED_CNT_W'(todc_pkg::LED_STEP_TICKS)))
    else $error("tick counter out of range");

  a_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && (item_i.op == todc_pkg::OP_SET) && (parse_i.status == todc_pkg::ST_OK))
    |=> (sec_q == '0) && (tick_q == '0))
    else $error("set time did not clear seconds and ticks");

endmodule

`default_nettype wire

>>> verif/tb_time_of_day_clock_with_led_chaser.sv
// Self-checking testbench for the time-of-day clock with LED chaser.
module tb_time_of_day_clock_with_led_chaser;
  import todc_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1200;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         MAX_REPORTS  = 10;

  typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] char_quad_t;

  typedef struct packed {
    todc_status_e      status;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [LED_W-1:0]  led;
    logic              prev_flag;
  } clock_reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // hour_tens_char[7:0], hour_units_char[15:8], minute_tens_char[23:16],
  // minute_units_char[31:24], new_changed_flag[32], zero fill[39:33]
  logic [39:0] s_axis_tdata;
  // op[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status[1:0], hours_now[6:2], minutes_now[12:7], seconds_now[18:13],
  // led_pattern[22:19], previous_changed_flag[23]
  logic [23:0] m_axis_tdata;

  // predicted clock state
  int unsigned    tod_tick;
  int unsigned    tod_sec;
  int unsigned    tod_min;
  int unsigned    tod_hour;
  logic [LED_W-1:0] tod_led;
  logic           tod_flag;

  clock_reading_t pending_readings[$];
  int             mismatch_count;
  bit             tx_gaps_on;
  int             hold_requests;
  int             hold_served;
  int             hold_left;
  int             rx_stall_left;
  int             rx_calm_left;

  time_of_day_clock_with_led_chaser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  // Advance the predicted clock by one operation and return the reading.
  function automatic clock_reading_t step_clock_model(logic [1:0] op, char_quad_t chars,
                                                       logic new_flag);
    clock_reading_t rd;
    bit             any_nul;
    bit             any_bad;
    int unsigned    hh;
    int unsigned    mm;
    rd.status    = ST_OK;
    rd.prev_flag = tod_flag;
    if (op == OP_TICK) begin
      tod_tick++;
      if (tod_tick % LED_STEP_TICKS == 0) tod_led = tod_led << 1;
      if (tod_led == '0) tod_led = LED_FIRST;
      if (tod_tick >= TICKS_PER_SECOND) begin
        tod_tick = 0;
        tod_sec++;
        tod_flag = 1'b1;
      end
      if (tod_sec >= SECONDS_PER_MINUTE) begin
        tod_sec = 0;
        tod_min++;
      end
      if (tod_min >= MINUTES_PER_HOUR) begin
        tod_min = 0;
        tod_hour++;
      end
      if (tod_hour >= HOURS_PER_DAY) tod_hour = 0;
    end else if (op == OP_SET) begin
      any_nul = 1'b0;
      any_bad = 1'b0;
      for (int k = 0; k < NUM_CHARS; k++) begin
        if (chars[k] == ASCII_NUL) any_nul = 1'b1;
        else if (chars[k] < ASCII_ZERO || chars[k] > ASCII_NINE) any_bad = 1'b1;
      end
      if (any_nul) begin
        rd.status = ST_SYNTAX;
      end else if (any_bad) begin
        rd.status = ST_VALUE;
      end else begin
        hh = (chars[0] - ASCII_ZERO) * 10 + (chars[1] - ASCII_ZERO);
        mm = (chars[2] - ASCII_ZERO) * 10 + (chars[3] - ASCII_ZERO);
        if (hh > MAX_HOUR || mm > MAX_MINUTE) begin
          rd.status = ST_VALUE;
        end else begin
          tod_hour = hh;
          tod_min  = mm;
          tod_sec  = 0;
          tod_tick = 0;
        end
      end
    end else if (op == OP_SWAP) begin
      tod_flag = new_flag;
    end
    rd.hours   = tod_hour[HOUR_W-1:0];
    rd.minutes = tod_min[MIN_W-1:0];
    rd.seconds = tod_sec[SEC_W-1:0];
    rd.led     = tod_led;
    return rd;
  endfunction

  // two decimal numbers 0..99 as four ASCII digits
  function automatic char_quad_t digits_for(int unsigned hh, int unsigned mm);
    char_quad_t q;
    q[0] = ASCII_ZERO + 8'(hh / 10);
    q[1] = ASCII_ZERO + 8'(hh % 10);
    q[2] = ASCII_ZERO + 8'(mm / 10);
    q[3] = ASCII_ZERO + 8'(mm % 10);
    return q;
  endfunction

  function automatic char_quad_t random_chars();
    return char_quad_t'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat; valid stays high after acceptance so back-to-back beats
  // never lower and raise it in the same step.
  task automatic send_item(logic [1:0] op, char_quad_t chars, logic new_flag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, new_flag, chars};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(step_clock_model(op, chars, new_flag));
  endtask

  task automatic send_set(char_quad_t chars);
    send_item(OP_SET, chars, 1'($urandom));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, random_chars(), 1'($urandom));
  endtask

  // Malformed set-time beat: NUL, stray character or out-of-range value.
  task automatic send_broken_set();
    char_quad_t q;
    q = digits_for($urandom_range(0, 23), $urandom_range(0, 59));
    case ($urandom_range(0, 4))
      0: q = random_chars();
      1: q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      2: q[$urandom_range(0, 3)] = ASCII_NUL;
      3: q = digits_for($urandom_range(24, 99), $urandom_range(0, 99));
      default: q = digits_for($urandom_range(0, 23), $urandom_range(60, 99));
    endcase
    send_set(q);
  endtask

  task automatic test_flag_exchange();
    send_item(OP_SWAP, random_chars(), 1'b0);
    send_item(OP_SWAP, random_chars(), 1'b0);
    send_item(OP_SWAP, random_chars(), 1'b1);
    send_item(OP_UNUSED, random_chars(), 1'b0);
    send_item(OP_UNUSED, '1, 1'b1);
  endtask

  task automatic test_set_time();
    char_quad_t q;
    send_set(digits_for(0, 0));
    send_set(digits_for(23, 59));
    send_set(digits_for(24, 0));
    send_set(digits_for(0, 60));
    send_set(digits_for(19, 9));
    send_set(digits_for(99, 99));
    for (int k = 0; k < NUM_CHARS; k++) begin
      q = digits_for(12, 34);
      q[k] = ASCII_NUL;
      send_set(q);
    end
    // NUL wins over a non-digit
    q = {ASCII_NUL, 8'hFF, 8'h2F, 8'h3A};
    send_set(q);
    q = digits_for(0, 0);
    q[0] = ASCII_ZERO - 8'd1;
    send_set(q);
    q = digits_for(0, 0);
    q[3] = ASCII_NINE + 8'd1;
    send_set(q);
    q = digits_for(11, 11);
    q[2] = 8'hFF;
    send_set(q);
    send_set('1);
    send_tick();
    send_tick();
  endtask

  // From 23:59:00 a few seconds of back-to-back ticks: second carries and
  // the LED wrap get exercised.
  task automatic test_second_rollover();
    tx_gaps_on = 1'b0;
    send_set(digits_for(23, 59));
    repeat (2 * TICKS_PER_SECOND + LED_STEP_TICKS) send_tick();
    tx_gaps_on = 1'b1;
  endtask

  // Receiver holds off while beats keep coming, so the block backs up.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (40) send_tick();
    send_item(OP_SWAP, random_chars(), 1'b0);
    send_set(digits_for(7, 7));
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) tx_gaps_on = !tx_gaps_on;
      // each run starts from a valid time at the top of a minute, often in the last minute of an hour
      if ($urandom_range(0, 1) == 0)
        send_set(digits_for($urandom_range(0, 23), 59));
      else
        send_set(digits_for($urandom_range(0, 23), $urandom_range(0, 59)));
      sent++;
      burst = $urandom_range(1, 250);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 85) send_tick();
        else if (r < 91) send_item(OP_SWAP, random_chars(), 1'($urandom));
        else if (r < 96) send_broken_set();
        else send_item(OP_UNUSED, random_chars(), 1'($urandom));
        sent++;
      end
    end
    tx_gaps_on = 1'b1;
  endtask

  // result side: check accepted beats and drive tready
  always @(posedge clk_i) begin
    clock_reading_t got;
    clock_reading_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = todc_status_e'(m_axis_tdata[1:0]);
        got.hours     = m_axis_tdata[6:2];
        got.minutes   = m_axis_tdata[12:7];
        got.seconds   = m_axis_tdata[18:13];
        got.led       = m_axis_tdata[22:19];
        got.prev_flag = m_axis_tdata[23];
        if (pending_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result beat: %h", m_axis_tdata);
        end else begin
          want = pending_readings.pop_front();
          if (got.status !== want.status || got.hours !== want.hours ||
              got.minutes !== want.minutes || got.seconds !== want.seconds ||
              got.led !== want.led || got.prev_flag !== want.prev_flag) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected st=%0d %0d:%0d:%0d led=%b prev=%b, got st=%0d %0d:%0d:%0d led=%b prev=%b",
                       want.status, want.hours, want.minutes, want.seconds, want.led,
                       want.prev_flag, got.status, got.hours, got.minutes, got.seconds,
                       got.led, got.prev_flag);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_calm_left > 0) begin
          rx_calm_left--;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:1]:   rx_calm_left  = $urandom_range(50, 300);
            [2:24]:  rx_stall_left = $urandom_range(1, 3);
            [25:27]: rx_stall_left = $urandom_range(10, 40);
            default: ;
          endcase
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_TICK;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    tx_gaps_on     = 1'b1;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    rx_stall_left  = 0;
    rx_calm_left   = 0;
    tod_tick       = 0;
    tod_sec        = 0;
    tod_min        = 0;
    tod_hour       = 0;
    tod_led        = LED_FIRST;
    tod_flag       = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flag_exchange();
    test_set_time();
    test_second_rollover();
    test_backpressure();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
